// ===== hdl/linear_probe_key_table_macros.svh =====
// ----------------------------------------------------------------------------
// linear_probe_key_table assertion macros
// Shared concurrent assertion forms for the key table checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_KEY_TABLE_MACROS_SVH
`define LINEAR_PROBE_KEY_TABLE_MACROS_SVH

// property checked on every clock edge outside reset
`define LPKT_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// signal holds while a transaction is stalled
`define LPKT_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
	`LPKT_ASSERT(lbl, clk, rstn, (vld && !rdy |=> $stable(sig)), msg)

`endif

// ===== hdl/lpkt_pkg.sv =====
// ----------------------------------------------------------------------------
// lpkt_pkg
// Types, codes and the key hash shared by the key table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpkt_pkg;

	localparam int KEY_IN_W   = 32;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 3;
	localparam int SLOT_OUT_W = 6;

	localparam int ADDR_SHIFT = 2;
	localparam int FOLD_SHIFT = 8;
	localparam int WORD_SHIFT = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_FIND        = 2'd0,
		CMD_FIND_INSERT = 2'd1,
		CMD_CLEAR       = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_FOUND    = 3'd0,
		STATUS_INSERTED = 3'd1,
		STATUS_ABSENT   = 3'd2,
		STATUS_FULL     = 3'd3,
		STATUS_NULL_KEY = 3'd4,
		STATUS_CLEARED  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_CLEAR,
		SEQ_READ,
		SEQ_CMP,
		SEQ_DONE
	} seq_state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

	function automatic logic [KEY_IN_W-1:0] fold_hash(input logic [KEY_IN_W-1:0] key);
		logic [KEY_IN_W-1:0] a;
		a = key >> ADDR_SHIFT;
		a = a ^ (a >> FOLD_SHIFT);
		a = a ^ (a >> WORD_SHIFT);
		return a;
	endfunction

endpackage

// ===== hdl/lpkt_key_store.sv =====
// ----------------------------------------------------------------------------
// lpkt_key_store
// Single-port key memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpkt_key_store #(
	parameter int SLOTS = 64,
	parameter int KW    = 32
) (
	input  logic                     clk,
	input  lpkt_pkg::mem_ctl_t       ctl,
	input  logic [$clog2(SLOTS)-1:0] addr,
	input  logic [KW-1:0]            wdata,
	output logic [KW-1:0]            rdata
);

	logic [KW-1:0] mem_q [SLOTS];
	logic [KW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[addr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/lpkt_seq.sv =====
// ----------------------------------------------------------------------------
// lpkt_seq
// Probe sequencer: clear sweep, linear probe with one key compare unit,
// last-hit shortcut and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpkt_seq #(
	parameter int SLOTS = 64,
	parameter int KW    = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  lpkt_pkg::cmd_t                      in_cmd,
	input  logic [KW-1:0]                       in_key,
	input  logic [$clog2(SLOTS)-1:0]            in_start,
	output lpkt_pkg::mem_ctl_t                  mem_ctl,
	output logic [$clog2(SLOTS)-1:0]            mem_addr,
	output logic [KW-1:0]                       mem_wdata,
	input  logic [KW-1:0]                       mem_rdata,
	output logic                                out_valid,
	input  logic                                out_ready,
	output lpkt_pkg::status_t                   out_status,
	output logic [lpkt_pkg::SLOT_OUT_W-1:0]     out_slot
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = IW + 1;
	localparam int SW = (IW > lpkt_pkg::SLOT_OUT_W) ? IW : lpkt_pkg::SLOT_OUT_W;
	localparam logic [IW-1:0] SlotMask = IW'(SLOTS - 1);
	localparam logic [CW-1:0] ProbeLimit = CW'(SLOTS);

	lpkt_pkg::seq_state_t state_q, state_d;

	logic [IW-1:0]      clr_q;
	logic               reply_q;
	logic               hit_valid_q;
	logic               out_valid_q;
	logic [KW-1:0]      key_q;
	logic               ins_q;
	logic [IW-1:0]      pos_q;
	logic [CW-1:0]      cnt_q;
	lpkt_pkg::status_t  res_status_q;
	logic [IW-1:0]      res_slot_q;
	logic [KW-1:0]      hit_key_q;
	logic [IW-1:0]      hit_slot_q;
	lpkt_pkg::status_t  out_status_q;
	logic [IW-1:0]      out_slot_q;

	logic               key_hit;
	logic               slot_empty;
	logic [CW-1:0]      cnt_inc;
	logic [IW-1:0]      slot_cur;
	logic               shortcut;
	logic               out_load;
	logic [SW-1:0]      slot_ext;

	assign key_hit    = (mem_rdata == key_q);
	assign slot_empty = (mem_rdata == '0);
	assign cnt_inc    = cnt_q + CW'(1);
	assign slot_cur   = pos_q & SlotMask;
	assign shortcut   = hit_valid_q && (hit_key_q == in_key);

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mem_ctl   = '0;
		mem_addr  = slot_cur;
		mem_wdata = key_q;
		out_load  = 1'b0;
		unique case (state_q)
			lpkt_pkg::SEQ_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_cmd == lpkt_pkg::CMD_CLEAR) begin
						state_d = lpkt_pkg::SEQ_CLEAR;
					end else if (in_key == '0 || shortcut) begin
						state_d = lpkt_pkg::SEQ_DONE;
					end else begin
						state_d = lpkt_pkg::SEQ_READ;
					end
				end
			end
			lpkt_pkg::SEQ_CLEAR: begin
				mem_ctl.wr_en = 1'b1;
				mem_addr      = clr_q;
				mem_wdata     = '0;
				if (clr_q == SlotMask) begin
					state_d = reply_q ? lpkt_pkg::SEQ_DONE : lpkt_pkg::SEQ_IDLE;
				end
			end
			lpkt_pkg::SEQ_READ: begin
				mem_ctl.rd_en = 1'b1;
				state_d       = lpkt_pkg::SEQ_CMP;
			end
			lpkt_pkg::SEQ_CMP: begin
				if (key_hit) begin
					state_d = lpkt_pkg::SEQ_DONE;
				end else if (slot_empty) begin
					mem_ctl.wr_en = ins_q;
					state_d       = lpkt_pkg::SEQ_DONE;
				end else if (cnt_inc == ProbeLimit) begin
					state_d = lpkt_pkg::SEQ_DONE;
				end else begin
					state_d = lpkt_pkg::SEQ_READ;
				end
			end
			lpkt_pkg::SEQ_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = lpkt_pkg::SEQ_IDLE;
				end
			end
			default: begin
				state_d = lpkt_pkg::SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpkt_pkg::SEQ_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			reply_q     <= 1'b0;
			hit_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			case (state_q)
				lpkt_pkg::SEQ_IDLE: begin
					if (in_valid && in_cmd == lpkt_pkg::CMD_CLEAR) begin
						clr_q       <= '0;
						reply_q     <= 1'b1;
						hit_valid_q <= 1'b0;
					end
				end
				lpkt_pkg::SEQ_CLEAR: begin
					clr_q <= clr_q + IW'(1);
				end
				lpkt_pkg::SEQ_CMP: begin
					if (key_hit || (slot_empty && ins_q)) begin
						hit_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lpkt_pkg::SEQ_IDLE: begin
				if (in_valid) begin
					key_q      <= in_key;
					ins_q      <= (in_cmd == lpkt_pkg::CMD_FIND_INSERT);
					pos_q      <= in_start & SlotMask;
					cnt_q      <= '0;
					if (in_cmd == lpkt_pkg::CMD_CLEAR) begin
						res_status_q <= lpkt_pkg::STATUS_CLEARED;
						res_slot_q   <= '0;
					end else if (in_key == '0) begin
						res_status_q <= lpkt_pkg::STATUS_NULL_KEY;
						res_slot_q   <= '0;
					end else if (shortcut) begin
						res_status_q <= lpkt_pkg::STATUS_FOUND;
						res_slot_q   <= hit_slot_q;
					end else begin
						res_slot_q   <= '0;
					end
				end
			end
			lpkt_pkg::SEQ_CMP: begin
				if (key_hit) begin
					res_status_q <= lpkt_pkg::STATUS_FOUND;
					res_slot_q   <= slot_cur;
					hit_key_q    <= key_q;
					hit_slot_q   <= slot_cur;
				end else if (slot_empty) begin
					if (ins_q) begin
						res_status_q <= lpkt_pkg::STATUS_INSERTED;
						res_slot_q   <= slot_cur;
						hit_key_q    <= key_q;
						hit_slot_q   <= slot_cur;
					end else begin
						res_status_q <= lpkt_pkg::STATUS_ABSENT;
					end
				end else if (cnt_inc == ProbeLimit) begin
					res_status_q <= ins_q ? lpkt_pkg::STATUS_FULL : lpkt_pkg::STATUS_ABSENT;
				end else begin
					pos_q <= pos_q + IW'(1);
					cnt_q <= cnt_inc;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign slot_ext   = SW'(out_slot_q);
	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_slot   = slot_ext[lpkt_pkg::SLOT_OUT_W-1:0];

endmodule

// ===== hdl/linear_probe_key_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_key_table
// Find, find-or-insert and clear on a linear-probed slot table of nonzero keys.
// A null key or last-hit match goes straight to the result register; a probe
// does one memory read and one compare per visited slot; clear sweeps every
// slot. One transaction at a time; not ready until the result is registered.
// Reset: sweeps every slot to empty the memory, not ready meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_probe_key_table #(
	parameter int TABLE_SLOTS = 64,
	parameter int KEY_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] key_address
	input  logic [1:0]  s_axis_tuser,   // [1:0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [5:0] slot_index, [7:6] zero
	output logic [2:0]  m_axis_tuser    // [2:0] status
);

	localparam int KeyW = (KEY_BITS < lpkt_pkg::KEY_IN_W) ? KEY_BITS : lpkt_pkg::KEY_IN_W;
	localparam int IdxW = $clog2(TABLE_SLOTS);

	logic [KeyW-1:0]                   key;
	logic [lpkt_pkg::KEY_IN_W-1:0]     key_hash;
	logic [IdxW-1:0]                   start_slot;
	lpkt_pkg::mem_ctl_t                mem_ctl;
	logic [IdxW-1:0]                   mem_addr;
	logic [KeyW-1:0]                   mem_wdata;
	logic [KeyW-1:0]                   mem_rdata;
	lpkt_pkg::status_t                 res_status;
	logic [lpkt_pkg::SLOT_OUT_W-1:0]   res_slot;

	assign key        = s_axis_tdata[KeyW-1:0];
	assign key_hash   = lpkt_pkg::fold_hash(lpkt_pkg::KEY_IN_W'(key));
	assign start_slot = key_hash[IdxW-1:0];

	lpkt_seq #(
		.SLOTS (TABLE_SLOTS),
		.KW    (KeyW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_cmd     (lpkt_pkg::cmd_t'(s_axis_tuser)),
		.in_key     (key),
		.in_start   (start_slot),
		.mem_ctl    (mem_ctl),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (res_status),
		.out_slot   (res_slot)
	);

	lpkt_key_store #(
		.SLOTS (TABLE_SLOTS),
		.KW    (KeyW)
	) u_store (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign m_axis_tdata = {2'b00, res_slot};
	assign m_axis_tuser = res_status;

endmodule

// ===== hdl/lpkt_checker.sv =====
// ----------------------------------------------------------------------------
// lpkt_checker
// Port-level checks on the key table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_probe_key_table_macros.svh"

module lpkt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);

	logic [10:0] m_payload;
	logic [33:0] s_payload;

	assign m_payload = {m_axis_tuser, m_axis_tdata};
	assign s_payload = {s_axis_tuser, s_axis_tdata};

	`LPKT_ASSERT(a_out_valid_holds, clk, arst_n, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid), "result dropped while stalled")
	`LPKT_ASSERT_HOLD(a_out_payload_holds, clk, arst_n, m_axis_tvalid, m_axis_tready, m_payload, "result changed while stalled")
	`LPKT_ASSERT_HOLD(a_in_payload_holds, clk, arst_n, s_axis_tvalid, s_axis_tready, s_payload, "request changed while stalled")
	`LPKT_ASSERT(a_one_at_a_time, clk, arst_n, (s_axis_tvalid && s_axis_tready |=> !s_axis_tready), "accepted a second transaction while busy")
	`LPKT_ASSERT(a_slot_zero_on_miss, clk, arst_n, (m_axis_tvalid && !(m_axis_tuser == lpkt_pkg::STATUS_FOUND || m_axis_tuser == lpkt_pkg::STATUS_INSERTED) |-> m_axis_tdata == 8'd0), "nonzero slot on a miss")

endmodule

bind linear_probe_key_table lpkt_checker u_lpkt_checker (.*);
